>>> hdl/mvm_pkg.sv
// Shared constants, codes and types of the multi-voice sample mixer.
// No dependencies; the mixer, the multiply unit, the checker and the testbench import it.
`timescale 1ns / 1ps

package mvm_pkg;

    // Sizes. SAMPLE_WORDS must be a power of two: word addresses wrap by masking.
    localparam int VOICE_COUNT  = 16;
    localparam int SAMPLE_WORDS = 65536;

    localparam int VOICE_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int SAMPLE_AW = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
    localparam int MASK_W    = 16;
    localparam int GAIN_FRAC = 12;

    // Request codes
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_RENDER = 2'd2;

    // One row of the voice table memory
    typedef struct packed {
        logic [15:0] base;
        logic [15:0] length;
        logic [15:0] position;
        logic [15:0] gain;
        logic        stereo;
        logic        looping;
    } voice_entry_t;

    localparam int VENT_W = $bits(voice_entry_t);

endpackage

>>> hdl/mvm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/mvm_mac.sv
// Average, gain multiply and saturating Q4.12 scale of one sample pair.
// Depends on mvm_pkg for the gain fraction width.
`timescale 1ns / 1ps

module mvm_mac (
    input  logic        clk,
    input  logic        mul_en,
    input  logic [15:0] word_a,
    input  logic [15:0] word_b,
    input  logic [15:0] gain,
    output logic [15:0] scaled
);
    import mvm_pkg::*;

    logic signed [16:0] sum;
    logic signed [16:0] avg17;
    logic signed [15:0] avg;
    logic signed [16:0] gain_s;
    logic signed [32:0] prod_next;
    logic signed [32:0] prod_reg;
    logic signed [32:0] prod_adj;
    logic signed [32:0] quot;

    // Truncate toward zero on both the average and the scale
    assign sum       = $signed({word_a[15], word_a}) + $signed({word_b[15], word_b});
    assign avg17     = (sum + $signed({16'b0, sum[16]})) >>> 1;
    assign avg       = avg17[15:0];
    assign gain_s    = $signed({1'b0, gain});
    assign prod_next = 33'(avg) * 33'(gain_s);

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_adj = prod_reg
                    + $signed({{(33 - GAIN_FRAC){1'b0}}, {GAIN_FRAC{prod_reg[32]}}});
    assign quot     = prod_adj >>> GAIN_FRAC;

    always_comb
    begin
        priority if (quot > 33'sd32767)
        begin
            scaled = 16'h7FFF;
        end
        else if (quot < -33'sd32768)
        begin
            scaled = 16'h8000;
        end
        else
        begin
            scaled = quot[15:0];
        end
    end

endmodule

>>> hdl/multi_voice_sample_mixer.sv
// Multi-voice PCM sample mixer: sample memory, voice table and render sequencer.
// Depends on mvm_pkg, mvm_ram and mvm_mac.
`timescale 1ns / 1ps
//
// Usage
//   One input channel (in_valid/in_ready) carries three kinds of transaction:
//   load writes one sample word, start sets up one voice slot, render mixes one
//   stereo frame. Only render produces an output transaction (left_out,
//   right_out, active_mask on out_valid/out_ready).
//   Load and start do not leave the idle state; in_ready stays high across them.
//   Render walks the voices in order: a voice that is not playing is only
//   scanned; a playing one goes through a voice table read, four sample reads
//   through the single sample memory read port, two gain multiplies and a
//   write-back. in_ready is low during a render.
//   The result sits in an output register: once it is loaded the block takes
//   the next transaction even if the receiver stalls; a following render holds
//   in its last cycle until the previous frame is taken.
//   Reset clears all voice flags and the output valid; the sample memory and
//   the voice table rows hold whatever they had and need no clearing pass,
//   since a row is read only after a start has written it.

module multi_voice_sample_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [15:0] address,
    input  logic [15:0] sample_value,
    input  logic [3:0]  voice_id,
    input  logic [15:0] length,
    input  logic        stereo,
    input  logic [15:0] volume,
    input  logic        loop_flag,
    input  logic        keep_flag,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] left_out,
    output logic [15:0] right_out,
    output logic [15:0] active_mask
);
    import mvm_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_VLOAD = 4'd2;
    localparam logic [3:0] ST_RD0   = 4'd3;
    localparam logic [3:0] ST_RD1   = 4'd4;
    localparam logic [3:0] ST_RD2   = 4'd5;
    localparam logic [3:0] ST_RD3   = 4'd6;
    localparam logic [3:0] ST_MULL  = 4'd7;
    localparam logic [3:0] ST_MULR  = 4'd8;
    localparam logic [3:0] ST_ACCR  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICE_COUNT - 1);

    // Control state
    logic [3:0]             state_reg, state_next;
    logic [VOICE_W-1:0]     v_reg, v_next;
    logic [VOICE_COUNT-1:0] alloc_reg, alloc_next;
    logic [VOICE_COUNT-1:0] play_reg, play_next;
    logic [VOICE_COUNT-1:0] kept_reg, kept_next;
    logic                   out_valid_reg, out_valid_next;

    // Datapath
    voice_entry_t ent_reg, ent_next;
    logic [15:0]  t_reg, t_next;
    logic         end_reg, end_next;
    logic [15:0]  w0_reg, w1_reg, w2_reg, w3_reg;
    logic [15:0]  acc_l_reg, acc_l_next;
    logic [15:0]  acc_r_reg, acc_r_next;
    logic [15:0]  left_reg, right_reg, mask_reg;

    logic                 accept;
    logic                 start_ok;
    logic                 out_free;
    voice_entry_t         ent_rd;
    logic [VENT_W-1:0]    vram_rdata;
    logic                 vram_we;
    logic [VOICE_W-1:0]   vram_waddr;
    voice_entry_t         vram_wdata;
    logic                 sram_we;
    logic [SAMPLE_AW-1:0] sram_raddr;
    logic [15:0]          sram_rdata;
    logic [16:0]          t17;
    logic [1:0]           step;
    logic [15:0]          pl, pr, tl, tr, idx;
    logic [16:0]          addr_sum;
    logic signed [17:0]   thr;
    logic                 mul_en;
    logic [15:0]          mac_a, mac_b, scaled;
    logic [MASK_W-1:0]    mask_now;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign start_ok  = ({28'b0, voice_id} < 32'(VOICE_COUNT));
    assign out_free  = !out_valid_reg || out_ready;
    assign ent_rd    = voice_entry_t'(vram_rdata);

    // Sample memory: loads write while idle, render reads one word a cycle
    assign sram_we = accept && (req_type == REQ_LOAD);

    mvm_ram #(
        .WIDTH (16),
        .DEPTH (SAMPLE_WORDS)
    ) u_sample_ram (
        .clk   (clk),
        .we    (sram_we),
        .waddr (SAMPLE_AW'(address)),
        .wdata (sample_value),
        .raddr (sram_raddr),
        .rdata (sram_rdata)
    );

    // Voice table: start writes a fresh row, render writes back the position
    always_comb
    begin
        vram_we    = 1'b0;
        vram_waddr = v_reg;
        vram_wdata = ent_reg;
        if (state_reg == ST_ACCR)
        begin
            vram_we             = 1'b1;
            vram_wdata.position = end_reg ? 16'd0 : t_reg;
        end
        else if (accept && (req_type == REQ_START) && start_ok)
        begin
            vram_we            = 1'b1;
            vram_waddr         = VOICE_W'(voice_id);
            vram_wdata.base     = address;
            vram_wdata.length   = length;
            vram_wdata.position = 16'd0;
            vram_wdata.gain     = volume;
            vram_wdata.stereo   = stereo;
            vram_wdata.looping  = loop_flag;
        end
    end

    mvm_ram #(
        .WIDTH (VENT_W),
        .DEPTH (VOICE_COUNT)
    ) u_voice_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (v_reg),
        .rdata (vram_rdata)
    );

    // Next position: advance by one frame, wrap once at the sound length
    always_comb
    begin
        t17 = {1'b0, ent_rd.position} + {15'b0, ent_rd.stereo ? 2'd2 : 2'd1};
        if (t17 >= {1'b0, ent_rd.length})
        begin
            t17 = t17 - {1'b0, ent_rd.length};
        end
    end

    // End of sound: t >= length - c - 1, signed
    assign thr = $signed({2'b00, ent_reg.length})
               - $signed({16'b0, ent_reg.stereo ? 2'd2 : 2'd1}) - 18'sd1;

    // Word indexes: left/right of the current frame and of the next frame
    assign pl = ent_reg.stereo ? {ent_reg.position[15:1], 1'b0} : ent_reg.position;
    assign pr = ent_reg.stereo ? {ent_reg.position[15:1], 1'b1} : ent_reg.position;
    assign tl = ent_reg.stereo ? {t_reg[15:1], 1'b0} : t_reg;
    assign tr = ent_reg.stereo ? {t_reg[15:1], 1'b1} : t_reg;
    assign step = 2'(state_reg - ST_RD0);

    always_comb
    begin
        unique case (step)
            2'd0:    idx = pl;
            2'd1:    idx = tl;
            2'd2:    idx = pr;
            default: idx = tr;
        endcase
    end

    assign addr_sum   = {1'b0, ent_reg.base} + {1'b0, idx};
    assign sram_raddr = SAMPLE_AW'(addr_sum);

    // Left pair multiplies in MULL, right pair in MULR
    assign mul_en = (state_reg == ST_MULL) || (state_reg == ST_MULR);
    assign mac_a  = (state_reg == ST_MULR) ? w2_reg : w0_reg;
    assign mac_b  = (state_reg == ST_MULR) ? w3_reg : w1_reg;

    mvm_mac u_mac (
        .clk    (clk),
        .mul_en (mul_en),
        .word_a (mac_a),
        .word_b (mac_b),
        .gain   (ent_reg.gain),
        .scaled (scaled)
    );

    // Allocation mask, voices beyond the port width are not shown
    genvar gi;
    generate
        for (gi = 0; gi < MASK_W; gi++)
        begin : g_mask
            if (gi < VOICE_COUNT)
            begin : g_on
                assign mask_now[gi] = alloc_reg[gi];
            end
            else
            begin : g_off
                assign mask_now[gi] = 1'b0;
            end
        end
    endgenerate

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        alloc_next     = alloc_reg;
        play_next      = play_reg;
        kept_next      = kept_reg;
        out_valid_next = out_valid_reg;
        ent_next       = ent_reg;
        t_next         = t_reg;
        end_next       = end_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_START:
                        begin
                            if (start_ok)
                            begin
                                alloc_next[VOICE_W'(voice_id)] = 1'b1;
                                play_next[VOICE_W'(voice_id)]  = 1'b1;
                                kept_next[VOICE_W'(voice_id)]  = keep_flag;
                            end
                        end
                        REQ_RENDER:
                        begin
                            v_next     = '0;
                            acc_l_next = '0;
                            acc_r_next = '0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            // load is handled by the memory write; code 3 is a no-op
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (alloc_reg[v_reg] && play_reg[v_reg])
                begin
                    state_next = ST_VLOAD;
                end
                else
                begin
                    // Drop a stopped voice unless it is kept
                    if (alloc_reg[v_reg] && !kept_reg[v_reg])
                    begin
                        alloc_next[v_reg] = 1'b0;
                    end
                    if (v_reg == LAST_VOICE)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        v_next = v_reg + 1'b1;
                    end
                end
            end
            ST_VLOAD:
            begin
                ent_next   = ent_rd;
                t_next     = t17[15:0];
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                end_next   = ($signed({2'b00, t_reg}) >= thr);
                state_next = ST_RD1;
            end
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:  state_next = ST_MULL;
            ST_MULL: state_next = ST_MULR;
            ST_MULR:
            begin
                acc_l_next = acc_l_reg + scaled;
                state_next = ST_ACCR;
            end
            ST_ACCR:
            begin
                acc_r_next = acc_r_reg + scaled;
                if (end_reg && !ent_reg.looping)
                begin
                    play_next[v_reg] = 1'b0;
                    if (!kept_reg[v_reg])
                    begin
                        alloc_next[v_reg] = 1'b0;
                    end
                end
                if (v_reg == LAST_VOICE)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                // Hold here until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            v_reg         <= '0;
            alloc_reg     <= '0;
            play_reg      <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            v_reg         <= v_next;
            alloc_reg     <= alloc_next;
            play_reg      <= play_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        ent_reg   <= ent_next;
        t_reg     <= t_next;
        end_reg   <= end_next;
        acc_l_reg <= acc_l_next;
        acc_r_reg <= acc_r_next;
        // Read data of the word whose address was issued in the previous state
        if (state_reg == ST_RD1)
        begin
            w0_reg <= sram_rdata;
        end
        if (state_reg == ST_RD2)
        begin
            w1_reg <= sram_rdata;
        end
        if (state_reg == ST_RD3)
        begin
            w2_reg <= sram_rdata;
        end
        if (state_reg == ST_MULL)
        begin
            w3_reg <= sram_rdata;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            left_reg  <= acc_l_reg;
            right_reg <= acc_r_reg;
            mask_reg  <= mask_now;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_out    = left_reg;
    assign right_out   = right_reg;
    assign active_mask = mask_reg;

endmodule

>>> hdl/mvm_checker.sv
// Port-level checks of the mixer's transaction timing, bound to the top level.
// Depends on mvm_pkg for request codes.
`timescale 1ns / 1ps

module mvm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  req_type,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] left_out,
    input logic [15:0] right_out,
    input logic [15:0] active_mask
);
    import mvm_pkg::*;

    // A render occupies the block
    a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (req_type == REQ_RENDER)) |=> !in_ready)
        else $error("input accepted right after a render");

    // Load and start leave the input ready for the next transaction
    a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && ((req_type == REQ_LOAD) || (req_type == REQ_START)))
        |=> in_ready)
        else $error("load or start held the input");

    // A frame appears only at the end of a render
    a_frame_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("frame without a render in progress");

    // A stalled frame holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(left_out) && $stable(right_out) && $stable(active_mask)))
        else $error("stalled frame changed");

endmodule

bind multi_voice_sample_mixer mvm_checker u_mvm_checker (.*);

>>> tb/multi_voice_sample_mixer_tb.sv
// Self-checking testbench for multi_voice_sample_mixer: directed table, then random
// load/start/render traffic under four handshake pressure phases, checked by a predictor.
// Depends on mvm_pkg and the mixer RTL; needs nothing else.
`timescale 1ns / 1ps

module multi_voice_sample_mixer_tb;

    import mvm_pkg::*;

    localparam logic [1:0]  REQ_UNUSED    = 2'd3;
    localparam logic [15:0] WINDOW_BASE   = 16'h1000;
    localparam int          PHASE_ITEMS   = 480;
    localparam int          DRAIN_CYCLES  = 20000;
    localparam int          SETTLE_CYCLES = 200;
    localparam longint      TIMEOUT_NS    = 64'd12_000_000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [15:0] sample;
        logic [3:0]  vid;
        logic [15:0] len;
        logic        stereo;
        logic [15:0] gain;
        logic        loop_en;
        logic        keep_en;
    } request_t;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic [15:0] mask;
    } frame_t;

    typedef struct {
        request_t rq;
        bit       typed;
        frame_t   frame;
    } stim_row_t;

    typedef struct {
        bit        allocated;
        bit        playing;
        bit        looping;
        bit        kept;
        bit        stereo;
        bit [15:0] base;
        bit [15:0] len;
        bit [15:0] pos;
        bit [15:0] gain;
    } voice_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [15:0] sample_value;
    logic [3:0]  voice_id;
    logic [15:0] length;
    logic        stereo;
    logic [15:0] volume;
    logic        loop_flag;
    logic        keep_flag;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] left_out;
    logic [15:0] right_out;
    logic [15:0] active_mask;

    // Predictor state: sample words, which of them hold data, and the voice table
    logic [15:0] sample_words [SAMPLE_WORDS];
    bit          word_written [SAMPLE_WORDS];
    voice_t      voices [VOICE_COUNT];

    frame_t      pending_frames [$];
    stim_row_t   directed_rows [$];

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int accepted_items = 0;
    int loads_sent = 0;
    int starts_sent = 0;
    int renders_sent = 0;
    int frames_checked = 0;
    int failures = 0;

    multi_voice_sample_mixer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .address     (address),
        .sample_value(sample_value),
        .voice_id    (voice_id),
        .length      (length),
        .stereo      (stereo),
        .volume      (volume),
        .loop_flag   (loop_flag),
        .keep_flag   (keep_flag),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_out    (left_out),
        .right_out   (right_out),
        .active_mask (active_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Average two words, truncating toward zero, then apply the Q4.12 gain with
    // truncation and saturation to 16 bits.
    function automatic logic [15:0] gain_scale(input logic [15:0] wa, input logic [15:0] wb,
                                               input logic [15:0] g);
        int     a;
        int     b;
        int     avg;
        longint gl;
        longint q;
        a   = int'($signed(wa));
        b   = int'($signed(wb));
        avg = (a + b) / 2;
        gl  = longint'(g);
        q   = (longint'(avg) * gl) / 4096;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // Word addresses a playing voice reads on its next frame (left now, right now,
    // left next, right next) and the position it moves to.
    function automatic void voice_taps(input voice_t vc, output logic [3:0][15:0] taps,
                                       output bit [15:0] next_pos);
        int c;
        int p;
        int t;
        int lenv;
        int pl;
        int tl;
        c    = vc.stereo ? 2 : 1;
        p    = int'(vc.pos);
        lenv = int'(vc.len);
        t    = p + c;
        if (t >= lenv)
            t = t - lenv;
        t  = t & 16'hFFFF;
        pl = vc.stereo ? (p & ~1) : p;
        tl = vc.stereo ? (t & ~1) : t;
        taps[0]  = 16'(int'(vc.base) + pl);
        taps[1]  = 16'(int'(vc.base) + pl + c - 1);
        taps[2]  = 16'(int'(vc.base) + tl);
        taps[3]  = 16'(int'(vc.base) + tl + c - 1);
        next_pos = t[15:0];
    endfunction

    // Advance the mixer state by one transaction; a render yields a frame.
    function automatic void apply_request(input request_t rq, output bit produced,
                                          output frame_t fr);
        logic [3:0][15:0] taps;
        bit [15:0]        next_pos;
        logic [15:0]      acc_l;
        logic [15:0]      acc_r;
        logic [15:0]      mask;
        int               c;
        produced = 1'b0;
        fr       = '0;
        case (rq.kind)
            REQ_LOAD:
            begin
                sample_words[rq.addr] = rq.sample;
                word_written[rq.addr] = 1'b1;
            end
            REQ_START:
            begin
                if (rq.vid < VOICE_COUNT)
                begin
                    voices[rq.vid].allocated = 1'b1;
                    voices[rq.vid].playing   = 1'b1;
                    voices[rq.vid].base      = rq.addr;
                    voices[rq.vid].len       = rq.len;
                    voices[rq.vid].stereo    = rq.stereo;
                    voices[rq.vid].gain      = rq.gain;
                    voices[rq.vid].looping   = rq.loop_en;
                    voices[rq.vid].kept      = rq.keep_en;
                    voices[rq.vid].pos       = '0;
                end
            end
            REQ_RENDER:
            begin
                acc_l = '0;
                acc_r = '0;
                mask  = '0;
                for (int v = 0; v < VOICE_COUNT; v++)
                begin
                    if (!voices[v].allocated)
                        continue;
                    if (!voices[v].playing)
                    begin
                        if (!voices[v].kept)
                            voices[v].allocated = 1'b0;
                        continue;
                    end
                    voice_taps(voices[v], taps, next_pos);
                    acc_l = acc_l + gain_scale(sample_words[taps[0]], sample_words[taps[2]],
                                               voices[v].gain);
                    acc_r = acc_r + gain_scale(sample_words[taps[1]], sample_words[taps[3]],
                                               voices[v].gain);
                    c = voices[v].stereo ? 2 : 1;
                    voices[v].pos = next_pos;
                    // End of sound: rewind, and stop unless looping
                    if (int'(next_pos) >= int'(voices[v].len) - c - 1)
                    begin
                        voices[v].pos = '0;
                        if (!voices[v].looping)
                        begin
                            voices[v].playing = 1'b0;
                            if (!voices[v].kept)
                                voices[v].allocated = 1'b0;
                        end
                    end
                end
                for (int v = 0; v < VOICE_COUNT && v < MASK_W; v++)
                    if (voices[v].allocated)
                        mask[v] = 1'b1;
                fr       = '{left: acc_l, right: acc_r, mask: mask};
                produced = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic stim_row_t stim_row(input logic [1:0] kind, input logic [15:0] addr,
                                           input logic [15:0] sample, input logic [3:0] vid,
                                           input logic [15:0] len, input logic st,
                                           input logic [15:0] gain, input logic lp,
                                           input logic kp, input bit typed,
                                           input logic [15:0] l, input logic [15:0] r,
                                           input logic [15:0] m);
        stim_row_t row;
        row.rq    = '{kind: kind, addr: addr, sample: sample, vid: vid, len: len,
                      stereo: st, gain: gain, loop_en: lp, keep_en: kp};
        row.typed = typed;
        row.frame = '{left: l, right: r, mask: m};
        return row;
    endfunction

    function automatic request_t random_request();
        request_t rq;
        int       pick;
        rq.kind    = REQ_RENDER;
        rq.addr    = 16'($urandom);
        rq.sample  = 16'($urandom);
        rq.vid     = 4'($urandom);
        rq.len     = 16'($urandom);
        rq.stereo  = 1'($urandom);
        rq.gain    = 16'($urandom);
        rq.loop_en = 1'($urandom);
        rq.keep_en = 1'($urandom);
        pick = $urandom_range(99);
        if (pick < 22)
        begin
            rq.kind = REQ_LOAD;
            if ($urandom_range(9) < 7)
                rq.addr = WINDOW_BASE + 16'($urandom_range(255));
            case ($urandom_range(9))
                0: rq.sample = 16'h7FFF;
                1: rq.sample = 16'h8000;
                default: rq.sample = 16'($urandom);
            endcase
        end
        else if (pick < 40)
        begin
            // Mostly short sounds inside the sample window, some anywhere
            rq.kind = REQ_START;
            if ($urandom_range(9) < 6)
                rq.addr = WINDOW_BASE + 16'($urandom_range(200));
            case ($urandom_range(19))
                0, 1, 2:                rq.len = 16'($urandom);
                3, 4, 5, 6, 7, 8, 9:    rq.len = 16'($urandom_range(80, 13));
                default:                rq.len = 16'($urandom_range(12));
            endcase
            case ($urandom_range(3))
                0: rq.gain = 16'h1000;
                1: rq.gain = 16'($urandom_range(16'h1FFF));
                default: rq.gain = 16'($urandom);
            endcase
            rq.loop_en = ($urandom_range(9) < 6);
        end
        else if (pick >= 96)
            rq.kind = REQ_UNUSED;
        return rq;
    endfunction

    // Present one transaction, hold it until accepted, then update the predictor.
    task automatic drive_transaction(input request_t rq, output bit produced,
                                     output frame_t fr);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rq.kind;
        address      <= rq.addr;
        sample_value <= rq.sample;
        voice_id     <= rq.vid;
        length       <= rq.len;
        stereo       <= rq.stereo;
        volume       <= rq.gain;
        loop_flag    <= rq.loop_en;
        keep_flag    <= rq.keep_en;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_request(rq, produced, fr);
        case (rq.kind)
            REQ_LOAD:   loads_sent++;
            REQ_START:  starts_sent++;
            REQ_RENDER: renders_sent++;
            default:    ;
        endcase
        if (rq.kind != REQ_UNUSED)
            accepted_items++;
    endtask

    // Write every word the next frame will read that holds no data yet, so that
    // no voice ever reads an unwritten sample.
    task automatic load_missing_taps();
        logic [3:0][15:0] taps;
        bit [15:0]        next_pos;
        request_t         ld;
        bit               produced;
        frame_t           fr;
        for (int v = 0; v < VOICE_COUNT; v++)
        begin
            if (!(voices[v].allocated && voices[v].playing))
                continue;
            voice_taps(voices[v], taps, next_pos);
            for (int k = 0; k < 4; k++)
            begin
                if (!word_written[taps[k]])
                begin
                    ld      = random_request();
                    ld.kind = REQ_LOAD;
                    ld.addr = taps[k];
                    drive_transaction(ld, produced, fr);
                end
            end
        end
    endtask

    task automatic submit(input request_t rq, input bit typed, input frame_t typed_frame);
        bit     produced;
        frame_t fr;
        if (rq.kind == REQ_RENDER)
            load_missing_taps();
        drive_transaction(rq, produced, fr);
        if (produced)
            pending_frames.push_back(typed ? typed_frame : fr);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            failures++;
        end
    endtask

    // Receiver: stall at the rate of the current phase
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Compare each accepted frame with the oldest expectation
    always @(posedge clk)
    begin
        frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t ns: unexpected frame, expected none, actual %h %h %h",
                         $time, left_out, right_out, active_mask);
                failures++;
            end
            else
            begin
                want = pending_frames.pop_front();
                check_field("left_out", want.left, left_out);
                check_field("right_out", want.right, right_out);
                check_field("active_mask", want.mask, active_mask);
                frames_checked++;
            end
        end
    end

    initial
    begin
        int phase_start;
        int drain;
        int sender_pct [4];
        int receiver_pct [4];

        sender_pct   = '{0, 69, 0, 24};
        receiver_pct = '{0, 0, 69, 24};

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        req_type     <= REQ_LOAD;
        address      <= '0;
        sample_value <= '0;
        voice_id     <= '0;
        length       <= '0;
        stereo       <= 1'b0;
        volume       <= '0;
        loop_flag    <= 1'b0;
        keep_flag    <= 1'b0;

        // kind, addr, sample, voice, length, stereo, gain, loop, keep | typed frame
        directed_rows.push_back(stim_row(REQ_RENDER, 16'h0000, 16'h0000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 1, 16'h0000, 16'h0000, 16'h0000));
        for (int a = 0; a < 4; a++)
            directed_rows.push_back(stim_row(REQ_LOAD, 16'(a), 16'h7FFF, 4'd0, 16'd0, 0,
                                             16'h0000, 0, 0, 0, '0, '0, '0));
        // Full-scale stereo voice at maximum gain saturates high, then frees itself
        directed_rows.push_back(stim_row(REQ_START, 16'h0000, 16'h0000, 4'd0, 16'd4, 1,
                                         16'hFFFF, 0, 0, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_RENDER, 16'h0000, 16'h0000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 1, 16'h7FFF, 16'h7FFF, 16'h0000));
        directed_rows.push_back(stim_row(REQ_RENDER, 16'h0000, 16'h0000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 1, 16'h0000, 16'h0000, 16'h0000));
        directed_rows.push_back(stim_row(REQ_LOAD, 16'hFFFE, 16'h8000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_LOAD, 16'hFFFF, 16'h8000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 0, '0, '0, '0));
        // Empty mono sound on the last voice: saturates low, stops, stays kept
        directed_rows.push_back(stim_row(REQ_START, 16'hFFFE, 16'h0000, 4'd15, 16'd0, 0,
                                         16'hFFFF, 0, 1, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_RENDER, 16'h0000, 16'h0000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 1, 16'h8000, 16'h8000, 16'h8000));
        directed_rows.push_back(stim_row(REQ_RENDER, 16'h0000, 16'h0000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 1, 16'h0000, 16'h0000, 16'h8000));
        // Looping mono voice at unity gain
        directed_rows.push_back(stim_row(REQ_START, 16'h0000, 16'h0000, 4'd3, 16'd4, 0,
                                         16'h1000, 1, 0, 0, '0, '0, '0));
        // Restart of the kept voice as a one-word stereo sound
        directed_rows.push_back(stim_row(REQ_START, 16'h0000, 16'h0000, 4'd15, 16'd1, 1,
                                         16'h0800, 0, 0, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_RENDER, 16'h0000, 16'h0000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF, 1,
                                         16'hFFFF, 1, 1, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_RENDER, 16'h0000, 16'h0000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 0, '0, '0, '0));
        // Longest sound, and a zero-gain two-word voice ending on every frame
        directed_rows.push_back(stim_row(REQ_START, 16'h0000, 16'h0000, 4'd1, 16'hFFFF, 1,
                                         16'h1000, 1, 1, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_START, 16'h0002, 16'h0000, 4'd7, 16'd2, 1,
                                         16'h0000, 1, 0, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_RENDER, 16'h0000, 16'h0000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_RENDER, 16'h0000, 16'h0000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_LOAD, 16'h5A5A, 16'hA5A5, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 0, '0, '0, '0));
        directed_rows.push_back(stim_row(REQ_RENDER, 16'h0000, 16'h0000, 4'd0, 16'd0, 0,
                                         16'h0000, 0, 0, 0, '0, '0, '0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            submit(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].frame);

        // Random traffic: no idling, sender gaps, receiver stalls, then both
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct    = sender_pct[phase];
            receiver_stall_pct = receiver_pct[phase];
            phase_start        = accepted_items;
            while (accepted_items - phase_start < PHASE_ITEMS)
                submit(random_request(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Drain outstanding frames, then let the block settle
        drain = 0;
        while (pending_frames.size() != 0 && drain < DRAIN_CYCLES)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_frames.size() != 0)
        begin
            $display("%0t ns: %0d frames expected but never delivered", $time,
                     pending_frames.size());
            failures += pending_frames.size();
        end

        $display("Drove %0d sample loads, %0d voice starts and %0d renders in four phases.",
                 loads_sent, starts_sent, renders_sent);
        $display("Compared %0d mixed frames; %0d failures seen.", frames_checked, failures);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/mvm_pkg.sv
hdl/mvm_ram.sv
hdl/mvm_mac.sv
hdl/multi_voice_sample_mixer.sv
hdl/mvm_checker.sv
tb/multi_voice_sample_mixer_tb.sv
